// ----- src/compacting_keyed_order_buffer_unit_defines.svh -----
// Assertion macros shared by the compacting keyed order buffer RTL.
`ifndef COMPACTING_KEYED_ORDER_BUFFER_UNIT_DEFINES_SVH
`define COMPACTING_KEYED_ORDER_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KOB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define KOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/kob_pkg.sv -----
// Package with the types, widths and codes of the compacting keyed order buffer.
`timescale 1ns / 1ps

package kob_pkg;

    localparam int DEPTH  = 16;
    localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int OP_W   = 3;
    localparam int SRC_W  = 16;
    localparam int KEY_W  = 32;
    localparam int TIME_W = 32;
    localparam int IDX_W  = 8;
    localparam int STS_W  = 2;
    localparam int SLOT_W = 4;
    localparam int OCC_W  = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OP_W-1:0] OP_FIRST  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STS_W-1:0] STS_INVALID = 2'd2;
    localparam logic [STS_W-1:0] STS_NONE    = 2'd3;

    typedef struct packed {
        logic [SRC_W-1:0]  source;
        logic [KEY_W-1:0]  order;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic take_next;
        logic load_new;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } kob_state_t;

endpackage

// ----- src/compacting_keyed_order_buffer_unit.sv -----
// Add, first position, clear, unknown operations and a remove of an unoccupied slot load
// their result into the output register from the decode state. A remove of an occupied slot
// and the final result of a search come after decode, one full rotation of the cell ring, wrap-up.
// One transaction is taken at a time, the next only once the block is back in idle;
// a stalled output register holds the ring and delays the next acceptance.
// Reset is asynchronous and active low; it empties the buffer at once (no clearing pass).
`timescale 1ns / 1ps
`include "compacting_keyed_order_buffer_unit_defines.svh"

module compacting_keyed_order_buffer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kob_pkg::OP_W-1:0]      operation,
    input  logic [kob_pkg::SRC_W-1:0]     source_id,
    input  logic [kob_pkg::KEY_W-1:0]     order_key,
    input  logic [kob_pkg::TIME_W-1:0]    arrival_time,
    input  logic [kob_pkg::IDX_W-1:0]     slot_index,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kob_pkg::STS_W-1:0]     status,
    output logic [kob_pkg::SLOT_W-1:0]    slot_out,
    output logic [kob_pkg::SRC_W-1:0]     source_out,
    output logic [kob_pkg::KEY_W-1:0]     order_out,
    output logic [kob_pkg::TIME_W-1:0]    time_out,
    output logic [kob_pkg::OCC_W-1:0]     occupancy,
    output logic                          last
);

    // The entries live in a ring of cells. Because adds go to the first free slot and
    // removes close the gap, the occupied slots always form a prefix of length count_reg,
    // so a slot is occupied exactly when its position is below the count.
    //
    // Add and clear act on the cells in place. Search and remove rotate the whole ring
    // once: each cycle the output is not stalled, every cell takes its upper neighbor's entry
    // and cell 0 wraps around to the top, so cell 0 presents the entry at position pos_reg.
    // After DEPTH steps the ring is back in its original order. A remove then closes the
    // gap in wrap-up: every cell at or above the removed position takes its neighbor's entry.

    kob_pkg::kob_state_t             state_reg, state_next;
    logic [kob_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [kob_pkg::POS_W-1:0]       pos_reg, pos_next;

    // Command captured at acceptance.
    logic [kob_pkg::OP_W-1:0]        cmd_op_reg, cmd_op_next;
    logic [kob_pkg::IDX_W-1:0]       cmd_idx_reg, cmd_idx_next;
    kob_pkg::entry_t                 cmd_entry_reg, cmd_entry_next;

    // Held entry: the most recent search match, or the entry that a remove takes out.
    logic                            pend_valid_reg, pend_valid_next;
    logic [kob_pkg::POS_W-1:0]       pend_pos_reg, pend_pos_next;
    kob_pkg::entry_t                 pend_entry_reg, pend_entry_next;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    logic [kob_pkg::STS_W-1:0]       out_status_reg, out_status_next;
    logic [kob_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    kob_pkg::entry_t                 out_entry_reg, out_entry_next;
    logic [kob_pkg::OCC_W-1:0]       out_occ_reg, out_occ_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic                            out_load;
    logic                            ring_step;
    logic                            remove_shift;
    logic                            add_load;
    logic                            head_valid;
    kob_pkg::entry_t                 zero_entry;

    kob_pkg::entry_t                 cell_q    [kob_pkg::DEPTH];
    kob_pkg::cell_ctrl_t             cell_ctrl [kob_pkg::DEPTH];

    // Cell chain.
    genvar g;
    generate
        for (g = 0; g < kob_pkg::DEPTH; g++)
        begin : g_cell
            kob_cell u_cell
            (
                .clk        (clk),
                .ctrl       (cell_ctrl[g]),
                .new_entry  (cmd_entry_reg),
                .next_entry (cell_q[(g + 1) % kob_pkg::DEPTH]),
                .entry      (cell_q[g])
            );
        end
    endgenerate

    // Per-cell control: rotate for a scan, shift down from the removed position, or take
    // the new entry when the cell sits at the first free position.
    always_comb
    begin
        for (int i = 0; i < kob_pkg::DEPTH; i++)
        begin
            cell_ctrl[i].take_next = ring_step ||
                                     (remove_shift && (32'(i) >= 32'(cmd_idx_reg)));
            cell_ctrl[i].load_new  = add_load && (count_reg == kob_pkg::CNT_W'(i));
        end
    end

    assign zero_entry = '0;
    assign out_free   = !out_valid_reg || !out_stall;
    assign head_valid = kob_pkg::CNT_W'(pos_reg) < count_reg;

    // Sequencer: takes one transaction at a time, runs it and loads the output register.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        cmd_op_next     = cmd_op_reg;
        cmd_idx_next    = cmd_idx_reg;
        cmd_entry_next  = cmd_entry_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_entry_next = pend_entry_reg;

        in_stall        = (state_reg != kob_pkg::ST_IDLE);
        ring_step       = 1'b0;
        remove_shift    = 1'b0;
        add_load        = 1'b0;
        out_load        = 1'b0;

        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            kob_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_op_next           = operation;
                    cmd_idx_next          = slot_index;
                    cmd_entry_next.source = source_id;
                    cmd_entry_next.order  = order_key;
                    cmd_entry_next.stamp  = arrival_time;
                    state_next            = kob_pkg::ST_EXEC;
                end
            end

            kob_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = kob_pkg::STS_OK;
                    out_slot_next   = '0;
                    out_entry_next  = zero_entry;
                    out_last_next   = 1'b1;
                    state_next      = kob_pkg::ST_IDLE;
                    unique case (cmd_op_reg)
                        kob_pkg::OP_ADD:
                        begin
                            if (count_reg == kob_pkg::CNT_W'(kob_pkg::DEPTH))
                            begin
                                out_status_next = kob_pkg::STS_FULL;
                            end
                            else
                            begin
                                add_load       = 1'b1;
                                count_next     = count_reg + 1'b1;
                                out_slot_next  = kob_pkg::SLOT_W'(count_reg);
                                out_entry_next = cmd_entry_reg;
                            end
                        end
                        kob_pkg::OP_REMOVE:
                        begin
                            if (32'(cmd_idx_reg) < 32'(count_reg))
                            begin
                                out_load   = 1'b0;
                                pos_next   = '0;
                                state_next = kob_pkg::ST_SCAN;
                            end
                            else
                            begin
                                out_status_next = kob_pkg::STS_INVALID;
                            end
                        end
                        kob_pkg::OP_SEARCH:
                        begin
                            out_load        = 1'b0;
                            pos_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = kob_pkg::ST_SCAN;
                        end
                        kob_pkg::OP_FIRST:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = kob_pkg::STS_NONE;
                            end
                            else
                            begin
                                out_entry_next = cell_q[0];
                            end
                        end
                        kob_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            out_status_next = kob_pkg::STS_INVALID;
                        end
                    endcase
                end
            end

            kob_pkg::ST_SCAN:
            begin
                // The ring only moves when a match could be handed to the output register.
                if (out_free)
                begin
                    ring_step = 1'b1;
                    pos_next  = pos_reg + 1'b1;
                    if (cmd_op_reg == kob_pkg::OP_SEARCH)
                    begin
                        if (head_valid && (cell_q[0].source == cmd_entry_reg.source))
                        begin
                            // The earlier match is known not to be the final one now.
                            if (pend_valid_reg)
                            begin
                                out_load        = 1'b1;
                                out_status_next = kob_pkg::STS_OK;
                                out_slot_next   = kob_pkg::SLOT_W'(pend_pos_reg);
                                out_entry_next  = pend_entry_reg;
                                out_last_next   = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_pos_next   = pos_reg;
                            pend_entry_next = cell_q[0];
                        end
                    end
                    else if (kob_pkg::IDX_W'(pos_reg) == cmd_idx_reg)
                    begin
                        pend_entry_next = cell_q[0];
                    end
                    if (pos_reg == kob_pkg::POS_W'(kob_pkg::DEPTH - 1))
                    begin
                        state_next = kob_pkg::ST_DONE;
                    end
                end
            end

            kob_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = kob_pkg::ST_IDLE;
                    if (cmd_op_reg == kob_pkg::OP_SEARCH)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_status_next = kob_pkg::STS_OK;
                            out_slot_next   = kob_pkg::SLOT_W'(pend_pos_reg);
                            out_entry_next  = pend_entry_reg;
                        end
                        else
                        begin
                            out_status_next = kob_pkg::STS_NONE;
                            out_slot_next   = '0;
                            out_entry_next  = zero_entry;
                        end
                    end
                    else
                    begin
                        remove_shift    = 1'b1;
                        count_next      = count_reg - 1'b1;
                        out_status_next = kob_pkg::STS_OK;
                        out_slot_next   = kob_pkg::SLOT_W'(cmd_idx_reg);
                        out_entry_next  = pend_entry_reg;
                    end
                end
            end

            default:
            begin
                state_next = kob_pkg::ST_IDLE;
            end
        endcase

        // Every result reports the occupancy after its operation.
        out_occ_next = out_load ? kob_pkg::OCC_W'(count_next) : out_occ_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kob_pkg::ST_IDLE;
            count_reg      <= '0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_op_reg     <= cmd_op_next;
        cmd_idx_reg    <= cmd_idx_next;
        cmd_entry_reg  <= cmd_entry_next;
        pend_pos_reg   <= pend_pos_next;
        pend_entry_reg <= pend_entry_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_entry_reg  <= out_entry_next;
        out_occ_reg    <= out_occ_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_out   = out_slot_reg;
    assign source_out = out_entry_reg.source;
    assign order_out  = out_entry_reg.order;
    assign time_out   = out_entry_reg.stamp;
    assign occupancy  = out_occ_reg;
    assign last       = out_last_reg;

    // The count never exceeds the number of cells.
    `KOB_ASSERT_NOW(a_count_range, 1'b1, count_reg <= kob_pkg::CNT_W'(kob_pkg::DEPTH), "count above depth")

    // A transaction that fails or finds nothing is a single final result with no entry.
    `KOB_ASSERT_NOW(a_fail_single, out_valid_reg && (out_status_reg != kob_pkg::STS_OK), out_last_reg && (out_slot_reg == '0), "failing result not final or carries a slot")

    // Acceptance always starts execution in the next cycle.
    `KOB_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_reg == kob_pkg::ST_EXEC, "accepted transaction not executed")

    // A held match only exists while a rotation or its wrap-up is in progress.
    `KOB_ASSERT_NOW(a_pend_scope, pend_valid_reg, (state_reg == kob_pkg::ST_SCAN) || (state_reg == kob_pkg::ST_DONE), "held match outside a scan")

endmodule

// ----- src/kob_cell.sv -----
// One storage cell of the buffer chain: holds an entry, loads a new one or takes its neighbor's.
`timescale 1ns / 1ps

module kob_cell
(
    input  logic                clk,
    input  kob_pkg::cell_ctrl_t ctrl,
    input  kob_pkg::entry_t     new_entry,
    input  kob_pkg::entry_t     next_entry,
    output kob_pkg::entry_t     entry
);

    kob_pkg::entry_t entry_reg;
    kob_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.take_next)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- tb/tb_compacting_keyed_order_buffer_unit.sv -----
// Self-checking testbench of the compacting keyed order buffer unit.
`timescale 1ns / 1ps

module tb_compacting_keyed_order_buffer_unit;

    // The run is ended here if it has not finished by then. The slowest correct run
    // (every search returning DEPTH matches, each match stalled by the receiver,
    // each request gapped by the sender) stays well below this count.
    localparam int LIMIT_CYCLES = 400000;

    // Remove and search hold the block through a full ring rotation; the extra margin
    // catches stray results after the last expected one has arrived.
    localparam int DRAIN_CYCLES = kob_pkg::DEPTH + 8;

    // Length of the receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES = 120;

    // Operation codes the block does not define; each must be rejected.
    localparam logic [kob_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [kob_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [kob_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

    // One input transaction.
    typedef struct {
        logic [kob_pkg::OP_W-1:0]   op;
        logic [kob_pkg::SRC_W-1:0]  source;
        logic [kob_pkg::KEY_W-1:0]  order;
        logic [kob_pkg::TIME_W-1:0] stamp;
        logic [kob_pkg::IDX_W-1:0]  index;
    } request_t;

    // One output transaction, field for field as the block presents it.
    typedef struct packed {
        logic [kob_pkg::STS_W-1:0]  status;
        logic [kob_pkg::SLOT_W-1:0] slot;
        logic [kob_pkg::SRC_W-1:0]  source;
        logic [kob_pkg::KEY_W-1:0]  order;
        logic [kob_pkg::TIME_W-1:0] stamp;
        logic [kob_pkg::OCC_W-1:0]  occupancy;
        logic                       last;
    } reply_t;

    // A row of the directed table. Rows with a fixed reply carry the single result
    // that can be read off directly: a status with zero entry fields and the
    // occupancy. All other rows are checked against the buffer predictor.
    typedef struct {
        request_t                   req;
        int                         reps;
        bit                         fixed_reply;
        logic [kob_pkg::STS_W-1:0]  status;
        int                         occupancy;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [kob_pkg::OP_W-1:0]    operation;
    logic [kob_pkg::SRC_W-1:0]   source_id;
    logic [kob_pkg::KEY_W-1:0]   order_key;
    logic [kob_pkg::TIME_W-1:0]  arrival_time;
    logic [kob_pkg::IDX_W-1:0]   slot_index;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [kob_pkg::STS_W-1:0]   status;
    logic [kob_pkg::SLOT_W-1:0]  slot_out;
    logic [kob_pkg::SRC_W-1:0]   source_out;
    logic [kob_pkg::KEY_W-1:0]   order_out;
    logic [kob_pkg::TIME_W-1:0]  time_out;
    logic [kob_pkg::OCC_W-1:0]   occupancy;
    logic                        last;

    // Predicted contents of the buffer, packed at the low slots.
    bit                          held[kob_pkg::DEPTH];
    logic [kob_pkg::SRC_W-1:0]   held_source[kob_pkg::DEPTH];
    logic [kob_pkg::KEY_W-1:0]   held_order[kob_pkg::DEPTH];
    logic [kob_pkg::TIME_W-1:0]  held_stamp[kob_pkg::DEPTH];
    int                          held_count;

    // Results of the request just predicted, and all results still owed by the block.
    reply_t                      step_replies[$];
    reply_t                      pending_replies[$];
    reply_t                      front_reply;

    stim_row_t                   directed_rows[$];
    logic [kob_pkg::SRC_W-1:0]   source_pool[4];
    bit                          filling;

    int                          send_idle_pct;
    int                          recv_idle_pct;
    int                          hold_requests;
    int                          hold_seen;
    int                          hold_left;
    int                          cycle_count;

    int                          fail_count;
    int                          requests_taken;
    int                          replies_seen;
    int                          full_rejects;
    int                          search_hits;
    int                          widest_search;
    int                          input_stall_cycles;

    compacting_keyed_order_buffer_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .source_id    (source_id),
        .order_key    (order_key),
        .arrival_time (arrival_time),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot_out     (slot_out),
        .source_out   (source_out),
        .order_out    (order_out),
        .time_out     (time_out),
        .occupancy    (occupancy),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Appends one result to those of the request being predicted.
    function automatic void note_reply(reply_t r);
        step_replies.insert(step_replies.size(), r);
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Builds one result from the predicted state. Without an entry, the slot and
    // entry fields stay zero, which is what every status result reports.
    function automatic reply_t entry_reply(logic [kob_pkg::STS_W-1:0] sts, int pos,
                                           bit with_entry, bit fin);
        reply_t r;
        r = '0;
        r.status = sts;
        if (with_entry)
        begin
            r.slot   = pos[kob_pkg::SLOT_W-1:0];
            r.source = held_source[pos];
            r.order  = held_order[pos];
            r.stamp  = held_stamp[pos];
        end
        r.occupancy = held_count[kob_pkg::OCC_W-1:0];
        r.last      = fin;
        return r;
    endfunction

    // Applies one accepted request to the predicted buffer and leaves the results
    // it causes in step_replies, in the order the block must emit them.
    function automatic void predict_buffer(request_t rq);
        int     pos;
        reply_t r;
        step_replies.delete();
        case (rq.op)
            kob_pkg::OP_ADD:
            begin
                // The lowest free slot takes the entry; the buffer is always packed,
                // so that slot is also the occupancy before the add.
                pos = -1;
                for (int i = kob_pkg::DEPTH - 1; i >= 0; i--)
                begin
                    if (!held[i])
                        pos = i;
                end
                if (held_count >= kob_pkg::DEPTH || pos < 0)
                begin
                    full_rejects++;
                    note_reply(entry_reply(kob_pkg::STS_FULL, 0, 1'b0, 1'b1));
                end
                else
                begin
                    held[pos]        = 1'b1;
                    held_source[pos] = rq.source;
                    held_order[pos]  = rq.order;
                    held_stamp[pos]  = rq.stamp;
                    held_count++;
                    note_reply(entry_reply(kob_pkg::STS_OK, pos, 1'b1, 1'b1));
                end
            end
            kob_pkg::OP_REMOVE:
            begin
                pos = int'(rq.index);
                if (pos >= kob_pkg::DEPTH || !held[pos])
                begin
                    note_reply(entry_reply(kob_pkg::STS_INVALID, 0, 1'b0, 1'b1));
                end
                else
                begin
                    // Capture the entry first; every later entry then moves down one.
                    r = entry_reply(kob_pkg::STS_OK, pos, 1'b1, 1'b1);
                    for (int i = pos; i < kob_pkg::DEPTH - 1; i++)
                    begin
                        held[i]        = held[i + 1];
                        held_source[i] = held_source[i + 1];
                        held_order[i]  = held_order[i + 1];
                        held_stamp[i]  = held_stamp[i + 1];
                    end
                    held[kob_pkg::DEPTH - 1] = 1'b0;
                    if (held_count > 0)
                        held_count--;
                    r.occupancy = held_count[kob_pkg::OCC_W-1:0];
                    note_reply(r);
                end
            end
            kob_pkg::OP_SEARCH:
            begin
                for (int i = 0; i < kob_pkg::DEPTH; i++)
                begin
                    if (held[i] && held_source[i] == rq.source)
                        note_reply(entry_reply(kob_pkg::STS_OK, i, 1'b1, 1'b0));
                end
                if (step_replies.size() == 0)
                begin
                    note_reply(entry_reply(kob_pkg::STS_NONE, 0, 1'b0, 1'b1));
                end
                else
                begin
                    step_replies[step_replies.size() - 1].last = 1'b1;
                    search_hits++;
                    if (step_replies.size() > widest_search)
                        widest_search = step_replies.size();
                end
            end
            kob_pkg::OP_FIRST:
            begin
                pos = -1;
                for (int i = kob_pkg::DEPTH - 1; i >= 0; i--)
                begin
                    if (held[i])
                        pos = i;
                end
                if (pos < 0)
                    note_reply(entry_reply(kob_pkg::STS_NONE, 0, 1'b0, 1'b1));
                else
                    note_reply(entry_reply(kob_pkg::STS_OK, pos, 1'b1, 1'b1));
            end
            kob_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < kob_pkg::DEPTH; i++)
                    held[i] = 1'b0;
                held_count = 0;
                note_reply(entry_reply(kob_pkg::STS_OK, 0, 1'b0, 1'b1));
            end
            default:
            begin
                note_reply(entry_reply(kob_pkg::STS_INVALID, 0, 1'b0, 1'b1));
            end
        endcase
    endfunction

    function automatic stim_row_t stim_row(logic [kob_pkg::OP_W-1:0] op,
                                           logic [kob_pkg::SRC_W-1:0] src,
                                           logic [kob_pkg::KEY_W-1:0] key,
                                           logic [kob_pkg::TIME_W-1:0] stamp,
                                           logic [kob_pkg::IDX_W-1:0] idx, int reps,
                                           bit fixed_reply,
                                           logic [kob_pkg::STS_W-1:0] sts, int occ);
        stim_row_t row;
        row.req.op       = op;
        row.req.source   = src;
        row.req.order    = key;
        row.req.stamp    = stamp;
        row.req.index    = idx;
        row.reps         = reps;
        row.fixed_reply  = fixed_reply;
        row.status       = sts;
        row.occupancy    = occ;
        return row;
    endfunction

    // Random request shaped around the predicted state. The add/remove mix swings
    // between filling and draining so that occupancy sweeps from empty to full;
    // most removes hit an occupied slot and most keys come from a small pool so
    // that searches find several matches.
    function automatic request_t random_request();
        request_t rq;
        int       add_weight;
        int       pick;
        rq.source = ($urandom_range(0, 99) < 80) ? source_pool[$urandom_range(0, 3)]
                                                 : kob_pkg::SRC_W'($urandom);
        rq.order  = $urandom;
        rq.stamp  = $urandom;
        rq.index  = kob_pkg::IDX_W'($urandom);
        if (held_count >= kob_pkg::DEPTH)
            filling = 1'b0;
        else if (held_count == 0)
            filling = 1'b1;
        add_weight = filling ? 45 : 15;
        pick = $urandom_range(0, 99);
        if (pick < add_weight)
        begin
            rq.op = kob_pkg::OP_ADD;
        end
        else if (pick < 60)
        begin
            rq.op = kob_pkg::OP_REMOVE;
            if (held_count > 0 && $urandom_range(0, 99) < 85)
                rq.index = kob_pkg::IDX_W'($urandom_range(0, held_count - 1));
        end
        else if (pick < 85)
        begin
            rq.op = kob_pkg::OP_SEARCH;
        end
        else if (pick < 93)
        begin
            rq.op = kob_pkg::OP_FIRST;
        end
        else if (pick < 95)
        begin
            rq.op = kob_pkg::OP_CLEAR;
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       rq.op = OP_RSVD5;
                1:       rq.op = OP_RSVD6;
                default: rq.op = OP_RSVD7;
            endcase
        end
        return rq;
    endfunction

    // Offers one request, waits for the handshake, records what the block owes for
    // it, then possibly idles the sender. A fixed reply replaces the predicted one,
    // but the predictor still runs so that its state follows the block.
    task automatic issue_request(request_t rq, bit fixed_reply,
                                 logic [kob_pkg::STS_W-1:0] sts, int occ);
        reply_t fixed;
        in_valid     <= 1'b1;
        operation    <= rq.op;
        source_id    <= rq.source;
        order_key    <= rq.order;
        arrival_time <= rq.stamp;
        slot_index   <= rq.index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_taken++;
        predict_buffer(rq);
        if (fixed_reply)
        begin
            fixed           = '0;
            fixed.status    = sts;
            fixed.occupancy = occ[kob_pkg::OCC_W-1:0];
            fixed.last      = 1'b1;
            pending_replies.insert(pending_replies.size(), fixed);
        end
        else
        begin
            foreach (step_replies[k])
                pending_replies.insert(pending_replies.size(), step_replies[k]);
        end
        // Valid is only lowered when a gap follows, so a back-to-back request never
        // sees valid dropped and raised within one time step.
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: random stalls at the current rate, or a long hold-off counted here
    // whenever the stimulus asks for one, so that the block backs up into its input.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Result checker: every accepted output transaction is matched against the
    // oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            input_stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: status %0d slot %0d source 0x%0h last %0d",
                       status, slot_out, source_out, last);
                fail_count++;
            end
            else
            begin
                front_reply = pending_replies.pop_front();
                check_field("status", 32'(front_reply.status), 32'(status));
                check_field("slot_out", 32'(front_reply.slot), 32'(slot_out));
                check_field("source_out", 32'(front_reply.source), 32'(source_out));
                check_field("order_out", front_reply.order, order_out);
                check_field("time_out", front_reply.stamp, time_out);
                check_field("occupancy", 32'(front_reply.occupancy), 32'(occupancy));
                check_field("last", 32'(front_reply.last), 32'(last));
            end
        end
    end

    // Watchdog: a run that has not finished by the limit has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        request_t  rq;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = kob_pkg::OP_ADD;
        source_id    = '0;
        order_key    = '0;
        arrival_time = '0;
        slot_index   = '0;

        for (int i = 0; i < kob_pkg::DEPTH; i++)
            held[i] = 1'b0;
        held_count         = 0;
        filling            = 1'b1;
        hold_requests      = 0;
        hold_seen          = 0;
        hold_left          = 0;
        fail_count         = 0;
        requests_taken     = 0;
        replies_seen       = 0;
        full_rejects       = 0;
        search_hits        = 0;
        widest_search      = 0;
        input_stall_cycles = 0;

        // The pool holds both extreme keys plus two ordinary ones.
        source_pool[0] = '0;
        source_pool[1] = '1;
        source_pool[2] = 16'h00C3;
        source_pool[3] = kob_pkg::SRC_W'($urandom);

        // First idling mix: the sender gaps now and then, the receiver stalls often.
        send_idle_pct = 25;
        recv_idle_pct = 58;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. It starts on the empty buffer, then walks the extremes of
        // every field, removal at and past the end, a buffer filled to the brim with
        // one key (so a search returns every slot), and clearing.
        add_row(stim_row(kob_pkg::OP_FIRST, '0, '0, '0, '0, 1, 1'b1, kob_pkg::STS_NONE, 0));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, '0, 1, 1'b1,
                         kob_pkg::STS_INVALID, 0));
        add_row(stim_row(kob_pkg::OP_SEARCH, '0, '0, '0, '0, 1, 1'b1, kob_pkg::STS_NONE, 0));
        add_row(stim_row(OP_RSVD5, '1, '1, '1, '1, 1, 1'b1, kob_pkg::STS_INVALID, 0));
        add_row(stim_row(kob_pkg::OP_ADD, '1, '1, '1, '0, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_ADD, '0, '0, '0, '0, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_ADD, '1, 32'h1234_5678, 32'h0001_8000, '0, 1,
                         1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_SEARCH, '1, '0, '0, '0, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_FIRST, '0, '0, '0, '0, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, '1, 1, 1'b1,
                         kob_pkg::STS_INVALID, 3));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, kob_pkg::IDX_W'(kob_pkg::DEPTH), 1,
                         1'b1, kob_pkg::STS_INVALID, 3));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, 8'd0, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, 8'd0, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_ADD, '1, 32'hA000_0000, 32'h0000_FFFF, '0,
                         kob_pkg::DEPTH - 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_ADD, '1, '1, '1, '0, 1, 1'b1, kob_pkg::STS_FULL,
                         kob_pkg::DEPTH));
        add_row(stim_row(kob_pkg::OP_SEARCH, '1, '0, '0, '0, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, kob_pkg::IDX_W'(kob_pkg::DEPTH - 1),
                         1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, kob_pkg::IDX_W'(kob_pkg::DEPTH - 1),
                         1, 1'b1, kob_pkg::STS_INVALID, kob_pkg::DEPTH - 1));
        add_row(stim_row(kob_pkg::OP_REMOVE, '0, '0, '0, 8'd5, 1, 1'b0, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_SEARCH, 16'h5A5A, '0, '0, '0, 1, 1'b1,
                         kob_pkg::STS_NONE, kob_pkg::DEPTH - 2));
        add_row(stim_row(kob_pkg::OP_CLEAR, '0, '0, '0, '0, 1, 1'b1, kob_pkg::STS_OK, 0));
        add_row(stim_row(kob_pkg::OP_FIRST, '0, '0, '0, '0, 1, 1'b1, kob_pkg::STS_NONE, 0));
        add_row(stim_row(OP_RSVD6, '0, '0, '0, '0, 1, 1'b1, kob_pkg::STS_INVALID, 0));

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            for (int k = 0; k < row.reps; k++)
            begin
                rq = row.req;
                rq.order = rq.order + kob_pkg::KEY_W'(k);
                issue_request(rq, row.fixed_reply, row.status, row.occupancy);
            end
        end

        // Random traffic in three idling mixes.
        repeat (124)
            issue_request(random_request(), 1'b0, kob_pkg::STS_OK, 0);

        send_idle_pct = 58;
        recv_idle_pct = 25;
        repeat (124)
            issue_request(random_request(), 1'b0, kob_pkg::STS_OK, 0);

        // No idling from here on. The receiver first holds off for a long stretch
        // while the sender keeps offering, so results back up and the input stalls.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        repeat (125)
            issue_request(random_request(), 1'b0, kob_pkg::STS_OK, 0);
        in_valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d input and %0d output transactions over %0d cycles.",
                 requests_taken, replies_seen, cycle_count);
        $display("Full rejects %0d, searches with matches %0d (widest %0d), %0d input stalls.",
                 full_rejects, search_hits, widest_search, input_stall_cycles);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/kob_pkg.sv
src/kob_cell.sv
src/compacting_keyed_order_buffer_unit.sv
tb/tb_compacting_keyed_order_buffer_unit.sv
